[rtl/core/ccmt_pkg.sv]
`default_nettype none

package ccmt_pkg;

   // Field widths that the interface fixes.
   localparam int OUT_W  = 63;
   localparam int FREQ_W = 32;
   localparam int TO_W   = 32;

   // The shared divider always runs a full 64-bit dividend through.
   localparam int DIV_W     = 64;
   localparam int DIV_CNT_W = 6;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

   // The shared multiplier takes a 44-bit and a 26-bit operand.
   localparam int MUL_A_W = 44;
   localparam int MUL_B_W = 26;

   localparam logic [FREQ_W-1:0]  USEC_PER_SEC   = 32'd1000000;
   localparam logic [MUL_B_W-1:0] USEC_MUL       = 26'd1000000;
   localparam logic [DIV_W-1:0]   MIN_ARM_TICKS  = 64'd1000;
   localparam logic [DIV_W-1:0]   OUT_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;
   // Largest whole-second count whose microsecond value still fits in 63 bits.
   localparam logic [DIV_W-1:0]   SEC_LIMIT      = 64'd9223372036854;
   // The tick rate per microsecond is below 4295, so 13 bits hold it.
   localparam int RATE_W = 13;

   // One million is 64 times 15625. The frequency drops its low six bits and
   // the remaining 26 bits are multiplied by ceil(2^40 / 15625); the top bits
   // from bit 40 up are then exactly the frequency divided by one million.
   localparam int                 RATE_PRE_SHIFT = 6;
   localparam int                 RATE_SHIFT     = 40;
   localparam logic [MUL_A_W-1:0] RATE_RECIP     = 44'd70368745;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_READ   = 2'd1,
      CMD_ARM    = 2'd2,
      CMD_DISARM = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV_SEC,
      S_MUL_FRAC,
      S_DIV_FRAC,
      S_MUL_SEC,
      S_READ_DONE,
      S_MUL_RATE,
      S_MUL_TICKS,
      S_ARM_DONE
   } state_type;

endpackage

`default_nettype wire

[rtl/core/cycle_counter_microsecond_timer.sv]
`default_nettype none

// Cycle counter with an equality comparator and an exact microsecond clock.
// Each request beat carries a command: tick advances the COUNTER_BITS-wide
// counter by one (it wraps) and raises the interrupt when the counter lands
// on the enabled compare value; read returns elapsed microseconds, computed
// as whole seconds times one million plus the scaled remainder divided by the
// clock frequency, saturating at 2^63-1 and zero while the frequency is zero;
// arm converts a timeout in microseconds to ticks (at least 1000), loads the
// compare value and enables it, posting the interrupt at once if the target
// wrapped to or below the current count; disarm only disables the compare.
// Every request gives exactly one response beat; for tick, disarm and a read
// at zero frequency it is valid in the cycle after the request is taken. A
// read then divides out whole seconds, scales the remainder on the shared
// multiplier, divides the scaled remainder, multiplies the whole seconds and
// finishes; both divisions are 64-step passes of the restoring divider. An
// arm does a reciprocal multiply on the shared multiplier giving the tick
// rate per microsecond, a second multiply scaling the timeout, and a step
// loading the target. A stalled response beat holds off the next request
// while the stall lasts; while a long command runs the request channel
// stalls and the frequency register does not take writes.
module cycle_counter_microsecond_timer
   import ccmt_pkg::*;
#(
   parameter int COUNTER_BITS = 63
) (
   input  wire                     clock,
   input  wire                     reset,

   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire  [FREQ_W-1:0]       csr_clock_frequency,

   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire  [1:0]              req_command,
   input  wire  [TO_W-1:0]         req_timeout_us,

   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic [OUT_W-1:0]        rsp_time_us,
   output logic [OUT_W-1:0]        rsp_tick_count,
   output logic                    rsp_timer_interrupt
);

   // Control and architectural state.
   state_type                 state_ff, state_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COUNTER_BITS-1:0]   count_ff, count_in;
   logic [COUNTER_BITS-1:0]   target_ff, target_in;
   logic                      enable_ff, enable_in;
   logic [FREQ_W-1:0]         freq_ff, freq_in;
   logic [DIV_CNT_W-1:0]      step_ff, step_in;

   // Datapath registers of the shared divider and multiplier.
   logic [DIV_W-1:0]          dvd_ff, dvd_in;
   logic [FREQ_W-1:0]         rem_ff, rem_in;
   logic [DIV_W-1:0]          secs_ff, secs_in;
   logic [MUL_B_W-1:0]        frac_ff, frac_in;
   logic [DIV_W-1:0]          prod_ff, prod_in;
   logic [TO_W-1:0]           timeout_ff, timeout_in;

   // Response payload registers.
   logic [OUT_W-1:0]          rsp_time_ff, rsp_time_in;
   logic [OUT_W-1:0]          rsp_count_ff, rsp_count_in;
   logic                      rsp_irq_ff, rsp_irq_in;

   logic                      req_accept;
   logic                      rsp_load;
   cmd_type                   cmd;

   // Divider step.
   logic [FREQ_W-1:0]         div_divisor;
   logic [FREQ_W:0]           div_trial;
   logic                      div_fits;
   logic [FREQ_W-1:0]         rem_step;
   logic [DIV_W-1:0]          dvd_step;

   // Multiplier.
   logic [MUL_A_W-1:0]        mul_a;
   logic [MUL_B_W-1:0]        mul_b;
   logic [DIV_W-1:0]          mul_p;

   // Read and arm finishing arithmetic.
   logic [DIV_W-1:0]          whole;
   logic [DIV_W-1:0]          ticks;
   logic [DIV_W-1:0]          arm_sum;

   assign cmd        = cmd_type'(req_command);
   assign req_stall  = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = (state_ff == S_IDLE);

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_time_us         = rsp_time_ff;
   assign rsp_tick_count      = rsp_count_ff;
   assign rsp_timer_interrupt = rsp_irq_ff;

   // One restoring step: shift the next dividend bit into the partial
   // remainder and subtract the divisor when it fits. The quotient bits
   // shift into the dividend register from the bottom.
   assign div_divisor = freq_ff;
   assign div_trial   = {rem_ff, dvd_ff[DIV_W-1]};
   assign div_fits    = (div_trial >= {1'b0, div_divisor});
   assign rem_step    = div_fits ? FREQ_W'(div_trial - {1'b0, div_divisor})
                                 : div_trial[FREQ_W-1:0];
   assign dvd_step    = {dvd_ff[DIV_W-2:0], div_fits};

   assign mul_p = mul_a * mul_b;

   assign whole   = prod_ff + DIV_W'(frac_ff);
   assign ticks   = (prod_ff < MIN_ARM_TICKS) ? MIN_ARM_TICKS : prod_ff;
   assign arm_sum = DIV_W'(count_ff) + ticks;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      count_in     = count_ff;
      target_in    = target_ff;
      enable_in    = enable_ff;
      freq_in      = freq_ff;
      step_in      = step_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      secs_in      = secs_ff;
      frac_in      = frac_ff;
      prod_in      = prod_ff;
      timeout_in   = timeout_ff;
      rsp_load     = 1'b0;
      rsp_time_in  = '0;
      rsp_irq_in   = 1'b0;
      mul_a        = secs_ff[MUL_A_W-1:0];
      mul_b        = USEC_MUL;

      if (csr_valid && csr_ready) begin
         freq_in = csr_clock_frequency;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               unique case (cmd)
                  CMD_TICK: begin
                     count_in   = count_ff + 1'b1;
                     rsp_irq_in = enable_ff && (count_in == target_ff);
                     rsp_load   = 1'b1;
                  end
                  CMD_READ: begin
                     if (freq_ff == '0) begin
                        rsp_load = 1'b1;
                     end else begin
                        dvd_in   = DIV_W'(count_ff);
                        rem_in   = '0;
                        step_in  = '0;
                        state_in = S_DIV_SEC;
                     end
                  end
                  CMD_ARM: begin
                     timeout_in = req_timeout_us;
                     state_in   = S_MUL_RATE;
                  end
                  CMD_DISARM: begin
                     enable_in = 1'b0;
                     rsp_load  = 1'b1;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end

         S_DIV_SEC: begin
            dvd_in  = dvd_step;
            rem_in  = rem_step;
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = S_MUL_FRAC;
            end
         end

         // Whole seconds are kept; the remainder scaled to microseconds
         // becomes the next dividend.
         S_MUL_FRAC: begin
            secs_in  = dvd_ff;
            mul_a    = MUL_A_W'(rem_ff);
            dvd_in   = mul_p;
            rem_in   = '0;
            step_in  = '0;
            state_in = S_DIV_FRAC;
         end

         S_DIV_FRAC: begin
            dvd_in  = dvd_step;
            rem_in  = rem_step;
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = S_MUL_SEC;
            end
         end

         S_MUL_SEC: begin
            frac_in  = dvd_ff[MUL_B_W-1:0];
            prod_in  = mul_p;
            state_in = S_READ_DONE;
         end

         S_READ_DONE: begin
            rsp_load = 1'b1;
            if ((secs_ff > SEC_LIMIT) || (whole > OUT_MAX)) begin
               rsp_time_in = OUT_MAX[OUT_W-1:0];
            end else begin
               rsp_time_in = whole[OUT_W-1:0];
            end
            state_in = S_IDLE;
         end

         // Ticks per microsecond by reciprocal multiply; the rate lands in
         // the low bits of the dividend register.
         S_MUL_RATE: begin
            mul_a    = RATE_RECIP;
            mul_b    = freq_ff[FREQ_W-1:RATE_PRE_SHIFT];
            dvd_in   = DIV_W'(mul_p[DIV_W-1:RATE_SHIFT]);
            state_in = S_MUL_TICKS;
         end

         S_MUL_TICKS: begin
            mul_a    = MUL_A_W'(timeout_ff);
            mul_b    = MUL_B_W'(dvd_ff[RATE_W-1:0]);
            prod_in  = mul_p;
            state_in = S_ARM_DONE;
         end

         // A target that wrapped to or below the count posts at once.
         S_ARM_DONE: begin
            target_in  = arm_sum[COUNTER_BITS-1:0];
            enable_in  = 1'b1;
            rsp_irq_in = (target_in <= count_ff);
            rsp_load   = 1'b1;
            state_in   = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
      rsp_count_in = OUT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         target_ff    <= '0;
         enable_ff    <= 1'b0;
         freq_ff      <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         target_ff    <= target_in;
         enable_ff    <= enable_in;
         freq_ff      <= freq_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      secs_ff    <= secs_in;
      frac_ff    <= frac_in;
      prod_ff    <= prod_in;
      timeout_ff <= timeout_in;
      if (rsp_load) begin
         rsp_time_ff  <= rsp_time_in;
         rsp_count_ff <= rsp_count_in;
         rsp_irq_ff   <= rsp_irq_in;
      end
   end

endmodule

`default_nettype wire

[test/microsecond_timer_checker.sv]
`timescale 1ns / 1ps

// Watches the three channels of the timer, keeps its own copy of the counter,
// the compare value and the frequency, and checks every response beat against
// the oldest outstanding prediction.
module microsecond_timer_checker
   import ccmt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [FREQ_W-1:0] csr_clock_frequency,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [1:0]        req_command,
   input  logic [TO_W-1:0]   req_timeout_us,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [OUT_W-1:0]  rsp_time_us,
   input  logic [OUT_W-1:0]  rsp_tick_count,
   input  logic              rsp_timer_interrupt,
   output int                mismatches,
   output int                outstanding
);

   typedef struct packed {
      logic [OUT_W-1:0] usec;
      logic [OUT_W-1:0] count;
      logic             irq;
   } timer_beat_type;

   logic [FREQ_W-1:0] freq_hz;
   logic [OUT_W-1:0]  cycles;
   logic [OUT_W-1:0]  match_value;
   logic              match_on;
   timer_beat_type    pending_beats[$];
   int                bad_beats = 0;
   int                waiting = 0;

   assign mismatches  = bad_beats;
   assign outstanding = waiting;

   // Whole seconds times a million plus the scaled remainder, clamped to 63 bits.
   function automatic logic [DIV_W-1:0] elapsed_usec(input logic [OUT_W-1:0] ticks,
                                                     input logic [FREQ_W-1:0] hz);
      logic [DIV_W-1:0] whole_sec;
      logic [DIV_W-1:0] part_usec;
      logic [DIV_W-1:0] total;
      if (hz == '0) begin
         return '0;
      end
      whole_sec = DIV_W'(ticks) / DIV_W'(hz);
      part_usec = ((DIV_W'(ticks) % DIV_W'(hz)) * DIV_W'(USEC_PER_SEC)) / DIV_W'(hz);
      if (whole_sec > OUT_MAX / DIV_W'(USEC_PER_SEC)) begin
         return OUT_MAX;
      end
      total = whole_sec * DIV_W'(USEC_PER_SEC) + part_usec;
      if (total > OUT_MAX) begin
         return OUT_MAX;
      end
      return total;
   endfunction

   // Applies one command to the timer copy and returns the beat it must produce.
   function automatic timer_beat_type step_timer(input cmd_type cmd,
                                                 input logic [TO_W-1:0] timeout);
      timer_beat_type   beat;
      logic [DIV_W-1:0] ticks;
      beat = '0;
      case (cmd)
         CMD_TICK: begin
            cycles   = cycles + 1'b1;
            beat.irq = match_on && (cycles == match_value);
         end
         CMD_READ: begin
            beat.usec = OUT_W'(elapsed_usec(cycles, freq_hz));
         end
         CMD_ARM: begin
            ticks = DIV_W'(timeout) * DIV_W'(freq_hz / USEC_PER_SEC);
            if (ticks < MIN_ARM_TICKS) begin
               ticks = MIN_ARM_TICKS;
            end
            match_value = OUT_W'(DIV_W'(cycles) + ticks);
            match_on    = 1'b1;
            beat.irq    = (match_value <= cycles);
         end
         CMD_DISARM: begin
            match_on = 1'b0;
         end
      endcase
      beat.count = cycles;
      return beat;
   endfunction

   always @(posedge clock) begin
      timer_beat_type want;
      if (reset) begin
         freq_hz     = '0;
         cycles      = '0;
         match_value = '0;
         match_on    = 1'b0;
         pending_beats.delete();
      end else begin
         // The response for a request can never come at the edge that takes
         // the request, so responses are retired before new requests queue up.
         if (rsp_valid && !rsp_stall) begin
            if (pending_beats.size() == 0) begin
               if (bad_beats < 10) begin
                  $display("%0t: response beat with no request outstanding", $realtime);
               end
               bad_beats++;
            end else begin
               want = pending_beats.pop_front();
               if (rsp_time_us !== want.usec || rsp_tick_count !== want.count ||
                   rsp_timer_interrupt !== want.irq) begin
                  if (bad_beats < 10) begin
                     $write("%0t: expected usec=%0d count=%0d irq=%0b", $realtime,
                            want.usec, want.count, want.irq);
                     $display(", got usec=%0d count=%0d irq=%0b",
                              rsp_time_us, rsp_tick_count, rsp_timer_interrupt);
                  end
                  bad_beats++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            freq_hz = csr_clock_frequency;
         end
         if (req_valid && !req_stall) begin
            pending_beats.push_back(step_timer(cmd_type'(req_command), req_timeout_us));
         end
      end
      waiting <= pending_beats.size();
   end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the microsecond timer. The checker beside the block
// does all prediction and comparison; this module only drives the request,
// response-stall and register channels and decides pass or fail at the end.
module testbench
   import ccmt_pkg::*;
();

   // A hung run stops here. The slowest legal run stays well below it.
   localparam int CYCLE_LIMIT = 1_000_000;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_valid;
   logic              csr_ready;
   logic [FREQ_W-1:0] csr_clock_frequency;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_command;
   logic [TO_W-1:0]   req_timeout_us;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [OUT_W-1:0]  rsp_time_us;
   logic [OUT_W-1:0]  rsp_tick_count;
   logic              rsp_timer_interrupt;

   int                mismatches;
   int                outstanding;
   int                sender_idle_pct = 0;
   int                stall_pct = 0;
   int                cycle_total = 0;
   // The frequency last written, which the countdown sequences need to size
   // their arm timeouts.
   logic [FREQ_W-1:0] hz_now;

   // The idle and stall percentages of each random phase, in order: no idling,
   // a mostly idle sender, a mostly stalling receiver, then both at once.
   int                idle_by_phase[4]  = '{0, 87, 0, 38};
   int                stall_by_phase[4] = '{0, 0, 87, 38};

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   cycle_counter_microsecond_timer #(
      .COUNTER_BITS(63)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_clock_frequency(csr_clock_frequency),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_timeout_us     (req_timeout_us),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_time_us        (rsp_time_us),
      .rsp_tick_count     (rsp_tick_count),
      .rsp_timer_interrupt(rsp_timer_interrupt)
   );

   microsecond_timer_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_clock_frequency(csr_clock_frequency),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_timeout_us     (req_timeout_us),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_time_us        (rsp_time_us),
      .rsp_tick_count     (rsp_tick_count),
      .rsp_timer_interrupt(rsp_timer_interrupt),
      .mismatches         (mismatches),
      .outstanding        (outstanding)
   );

   // The receiver stalls at random with the probability of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Watchdog: a run that never drains ends here as a failure.
   always @(posedge clock) begin
      cycle_total <= cycle_total + 1;
      if (cycle_total == CYCLE_LIMIT) begin
         $display("cycle_counter_microsecond_timer: mismatch");
         $finish;
      end
   end

   // Presents one request beat and holds it until the block takes it. Valid
   // stays high into the next beat unless the sender decides to idle, in which
   // case it drops and stays low for whole cycles until the next beat.
   task automatic send_beat(input cmd_type cmd, input logic [TO_W-1:0] timeout);
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_timeout_us <= timeout;
      do @(posedge clock); while (req_stall);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Waits until every request has its response. Since each command yields
   // exactly one beat, the block is idle once the checker has nothing left.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Frequency writes only happen while the block is idle.
   task automatic write_frequency(input logic [FREQ_W-1:0] hz);
      wait_idle();
      hz_now              = hz;
      csr_valid           <= 1'b1;
      csr_clock_frequency <= hz;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // A free mix of all four commands. Timeouts ride along on every command so
   // that the ignored field sees random values too; arms use either a full
   // random timeout or a tiny one that hits the 1000-tick floor at low rates.
   task automatic random_mix(input int count);
      int unsigned roll;
      repeat (count) begin
         roll = $urandom_range(99);
         if (roll < 60) begin
            send_beat(CMD_TICK, $urandom);
         end else if (roll < 75) begin
            send_beat(CMD_READ, $urandom);
         end else if (roll < 90) begin
            send_beat(CMD_ARM, $urandom_range(1) ? $urandom : $urandom_range(3));
         end else begin
            send_beat(CMD_DISARM, $urandom);
         end
      end
   endtask

   // Arms the comparator with a target close ahead and then ticks the counter past
   // the target so that a compare match actually fires. Reads are sprinkled
   // in so that the counter is also converted while the comparator runs.
   task automatic countdown();
      int unsigned       rate;
      int unsigned       steps;
      logic [TO_W-1:0]   timeout;
      rate = hz_now / USEC_PER_SEC;
      if (rate == 0) begin
         timeout = $urandom;
      end else if (rate > 1000) begin
         timeout = '0;
      end else begin
         timeout = $urandom_range(1000 / rate + 1);
      end
      steps = timeout * rate;
      if (steps < MIN_ARM_TICKS) begin
         steps = 32'(MIN_ARM_TICKS);
      end
      send_beat(CMD_ARM, timeout);
      repeat (steps + 4) begin
         send_beat(CMD_TICK, $urandom);
         if ($urandom_range(99) < 4) begin
            send_beat(CMD_READ, $urandom);
         end
      end
   endtask

   initial begin
      reset               <= 1'b1;
      csr_valid           <= 1'b0;
      csr_clock_frequency <= '0;
      req_valid           <= 1'b0;
      req_command         <= CMD_TICK;
      req_timeout_us      <= '0;
      hz_now              = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Zero frequency after reset: reads give zero and any arm falls back to
      // the 1000-tick floor, even with the largest timeout.
      send_beat(CMD_READ, '0);
      send_beat(CMD_TICK, '1);
      send_beat(CMD_ARM, '0);
      send_beat(CMD_ARM, '1);
      send_beat(CMD_DISARM, '1);
      send_beat(CMD_TICK, '0);
      send_beat(CMD_READ, '0);

      // Largest frequency: the biggest tick rate times the biggest timeout.
      write_frequency('1);
      send_beat(CMD_READ, '0);
      send_beat(CMD_ARM, '1);
      send_beat(CMD_ARM, '0);
      repeat (3) send_beat(CMD_TICK, '0);
      send_beat(CMD_READ, '1);
      send_beat(CMD_DISARM, '0);

      // One cycle per second: every tick is a whole second.
      write_frequency(32'd1);
      send_beat(CMD_READ, '0);
      send_beat(CMD_TICK, '0);
      send_beat(CMD_READ, '0);

      // Just under one tick per microsecond truncates the rate to zero.
      write_frequency(32'd999_999);
      send_beat(CMD_ARM, 32'd5000);
      send_beat(CMD_READ, '0);

      // Exactly one tick per microsecond: the timeout is taken as ticks.
      write_frequency(32'd1_000_000);
      send_beat(CMD_ARM, 32'd1500);
      send_beat(CMD_READ, '0);

      // Random phases, each at its own frequency and idling pattern. The last
      // phase, with both sides idling, also runs a countdown so that a compare
      // match is seen under handshake pressure from both ends.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       write_frequency(32'd1_000_000);
            1:       write_frequency('1);
            2:       write_frequency($urandom);
            default: write_frequency(32'd1);
         endcase
         sender_idle_pct = idle_by_phase[phase];
         stall_pct       = stall_by_phase[phase];
         random_mix(20);
         if (phase == 3) begin
            countdown();
         end
         random_mix(20);
      end

      // Drain, then give the block a read's worth of cycles to show any
      // stray beat before the verdict.
      wait_idle();
      repeat (150) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("cycle_counter_microsecond_timer: match");
      end else begin
         $display("cycle_counter_microsecond_timer: mismatch");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/ccmt_pkg.sv
rtl/core/cycle_counter_microsecond_timer.sv
test/microsecond_timer_checker.sv
test/testbench.sv
